// ===== rtl/core/rfr_pkg.sv =====
// Shared types, codes and the CRC byte function of the response frame receiver.
package rfr_pkg;

  localparam int BUF_DEPTH_DEF = 256;
  localparam int CMP_W = 10;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ARM  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [2:0] V_OK       = 3'd0;
  localparam logic [2:0] V_HEADER   = 3'd1;
  localparam logic [2:0] V_COMMAND  = 3'd2;
  localparam logic [2:0] V_STATUS   = 3'd3;
  localparam logic [2:0] V_CRC      = 3'd4;
  localparam logic [2:0] V_TIMEOUT  = 3'd5;
  localparam logic [2:0] V_OVERFLOW = 3'd6;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CMD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_GAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  HDR_MARK = 8'hFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  verdict;
    logic [7:0]  data_length;
    logic [15:0] module_status;
    logic [7:0]  data_byte;
  } out_t;

  function automatic logic [15:0] rfr_crc_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
    logic [15:0] r;
    logic        top;
    r = crc_in;
    for (int i = 7; i >= 0; i--) begin
      top = r[15];
      r = {r[14:0], b[i]};
      if (top) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rfr_store.sv =====
// Receive byte store: one write port and one registered read port.
module rfr_store #(
  parameter int DEPTH = rfr_pkg::BUF_DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/response_frame_receiver_crc16.sv =====
// Top level of the response frame receiver with CRC-16 check and idle-gap framing.
//
// The input channel carries one operation per beat: a received byte, a tick, an
// arm that clears the frame state, or a readback of one data byte. A tick that
// ends the frame after the idle gap, or that passes the response timeout, gives
// one verdict beat; a readback always gives one beat; other operations give none.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// One beat is accepted per cycle while in_stall is low. A result is registered
// first in the read stage, along with the registered read of the byte store, and
// then in the output register. The received bytes live in a single-port-write,
// registered-read memory; the CRC is updated one byte per beat, trailing the
// stream by two bytes so that the trailer is left out.
// When the output is stalled, one further result is held in the read stage, and
// after that in_stall rises until the output drains. Reset restores the register
// defaults and clears the frame state; the byte store is not cleared, and reads
// are limited to bytes received since the last arm.
module response_frame_receiver_crc16 #(
  parameter int BUF_DEPTH = rfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rfr_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rfr_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [rfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfr_pkg::CFG_W-1:0]      cfg_data
);

  import rfr_pkg::*;

  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int AW = $clog2(BUF_DEPTH);

  logic [7:0]    expected_cmd;
  logic [15:0]   idle_gap_ticks;
  logic [16:0]   response_timeout_ticks;

  logic [CW-1:0] rx_count;
  logic [1:0]    rx_phase;
  logic [15:0]   gap_count;
  logic [16:0]   wait_count;
  logic [15:0]   crc_reg;
  logic [7:0]    lag0;
  logic [7:0]    lag1;
  logic [7:0]    hdr [5];
  logic          overflow_flag;

  logic          p_valid;
  logic          p_kind;
  logic [2:0]    p_verdict;
  logic [7:0]    p_len;
  logic [15:0]   p_status;
  logic          p_rd_ok;
  logic [7:0]    rd_data;

  logic          take;
  logic          p_move;
  logic          has_result;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] len_plus;
  logic [CMP_W-1:0] pos;
  logic          rd_ok;
  logic [2:0]    judge;
  logic [15:0]   gap_lim;
  logic [15:0]   gap_next;
  logic [16:0]   wait_next;
  logic          frame_end;
  logic          timed_out;
  logic          tick_result;
  logic          byte_live;
  logic          wr_en;
  logic          rd_en;

  assign in_stall = p_valid && out_valid && out_stall;
  assign take     = in_valid && !in_stall;
  assign p_move   = p_valid && (!out_valid || !out_stall);

  assign count_ext = {{(CMP_W - CW){1'b0}}, rx_count};
  assign len_plus  = CMP_W'(hdr[1]) + CMP_W'(7);
  assign pos       = CMP_W'(in_data.read_index) + CMP_W'(5);
  assign rd_ok     = pos < count_ext;

  always_comb begin
    if (hdr[0] != HDR_MARK) begin
      judge = V_HEADER;
    end else if (hdr[2] != expected_cmd) begin
      judge = V_COMMAND;
    end else if ({hdr[3], hdr[4]} != 16'd0) begin
      judge = V_STATUS;
    end else if (overflow_flag) begin
      judge = V_OVERFLOW;
    end else if (count_ext != len_plus || {lag1, lag0} != crc_reg) begin
      judge = V_CRC;
    end else begin
      judge = V_OK;
    end
  end

  assign gap_lim     = (idle_gap_ticks == 16'd0) ? 16'd1 : idle_gap_ticks;
  assign gap_next    = (gap_count != 16'hFFFF) ? gap_count + 16'd1 : gap_count;
  assign wait_next   = (wait_count != 17'h1FFFF) ? wait_count + 17'd1 : wait_count;
  assign frame_end   = (rx_phase == PH_RECV) && (gap_next >= gap_lim);
  assign timed_out   = (response_timeout_ticks != 17'd0) &&
                       (wait_next > response_timeout_ticks);
  assign tick_result = (rx_phase != PH_DONE) && (frame_end || timed_out);
  assign has_result  = (in_data.opcode == OP_READ) ||
                       ((in_data.opcode == OP_TICK) && tick_result);
  assign byte_live   = take && (in_data.opcode == OP_BYTE) && (rx_phase != PH_DONE);
  assign wr_en       = byte_live && (rx_count < CW'(BUF_DEPTH));
  assign rd_en       = take && (in_data.opcode == OP_READ);

  rfr_store #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rx_count[AW-1:0]),
    .wr_data (in_data.rx_byte),
    .rd_en   (rd_en),
    .rd_addr (pos[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_cmd           <= 8'd0;
      idle_gap_ticks         <= 16'd10;
      response_timeout_ticks <= 17'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_CMD: expected_cmd <= cfg_data[7:0];
        REG_IDLE_GAP:     idle_gap_ticks <= cfg_data[15:0];
        REG_TIMEOUT:      response_timeout_ticks <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && in_data.opcode == OP_ARM)) begin
      rx_count      <= '0;
      rx_phase      <= PH_IDLE;
      gap_count     <= 16'd0;
      wait_count    <= 17'd0;
      crc_reg       <= CRC_INIT;
      lag0          <= 8'd0;
      lag1          <= 8'd0;
      overflow_flag <= 1'b0;
      for (int k = 0; k < 5; k++) begin
        hdr[k] <= 8'd0;
      end
    end else if (byte_live) begin
      if (rx_count >= CW'(3)) begin
        crc_reg <= rfr_crc_byte(crc_reg, lag1);
      end
      lag1 <= lag0;
      lag0 <= in_data.rx_byte;
      for (int k = 0; k < 5; k++) begin
        if (rx_count == CW'(k)) begin
          hdr[k] <= in_data.rx_byte;
        end
      end
      if (wr_en) begin
        rx_count <= rx_count + CW'(1);
      end else begin
        overflow_flag <= 1'b1;
      end
      rx_phase  <= PH_RECV;
      gap_count <= 16'd0;
    end else if (take && in_data.opcode == OP_TICK && rx_phase != PH_DONE) begin
      wait_count <= wait_next;
      if (rx_phase == PH_RECV) begin
        gap_count <= gap_next;
      end
      if (tick_result) begin
        rx_phase <= PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (take && has_result) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_result) begin
      p_kind   <= (in_data.opcode == OP_READ);
      p_len    <= hdr[1];
      p_status <= {hdr[3], hdr[4]};
      p_rd_ok  <= (in_data.opcode == OP_READ) && rd_ok;
      if (in_data.opcode == OP_READ) begin
        p_verdict <= V_OK;
      end else if (frame_end) begin
        p_verdict <= judge;
      end else begin
        p_verdict <= V_TIMEOUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_data.result_kind   <= p_kind;
      out_data.verdict       <= p_verdict;
      out_data.data_length   <= p_len;
      out_data.module_status <= p_status;
      out_data.data_byte     <= p_rd_ok ? rd_data : 8'd0;
    end
  end

endmodule
